FILE: rtl/isc_pkg.sv
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types, character codes and keyword table for the include scanner.
// ----------------------------------------------------------------------------
package isc_pkg;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChLess    = 8'h3C;
  localparam logic [7:0] ChGreater = 8'h3E;
  localparam logic [7:0] ChUnder   = 8'h5F;

  // length of the keyword "include"
  localparam logic [2:0] KwLen = 3'd7;

  // result queue depth
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] name_byte;
    logic       angle_form;
    logic       name_end;
    logic       name_closed;
    logic       run_last;
  } isc_item_t;

  // results of one scanned byte: up to two items
  typedef struct packed {
    logic [1:0] cnt;
    isc_item_t  item0;
    isc_item_t  item1;
  } isc_push_t;

  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h69; // i
      3'd1:    ch = 8'h6E; // n
      3'd2:    ch = 8'h63; // c
      3'd3:    ch = 8'h6C; // l
      3'd4:    ch = 8'h75; // u
      3'd5:    ch = 8'h64; // d
      3'd6:    ch = 8'h65; // e
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h41 && c <= 8'h5A) || (c == ChUnder);
  endfunction

endpackage

FILE: rtl/isc_if.sv
// ----------------------------------------------------------------------------
// isc interfaces
// Valid/ready channels for source bytes and for name result items.
// ----------------------------------------------------------------------------
interface isc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       stream_last;

  modport source (output valid, text_byte, stream_last, input ready);
  modport sink   (input valid, text_byte, stream_last, output ready);
endinterface

interface isc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_byte;
  logic       angle_form;
  logic       name_end;
  logic       name_closed;
  logic       run_last;

  modport source (output valid, name_byte, angle_form, name_end, name_closed,
                  run_last, input ready);
  modport sink   (input valid, name_byte, angle_form, name_end, name_closed,
                  run_last, output ready);
endinterface

FILE: rtl/include_directive_scanner.sv
// ----------------------------------------------------------------------------
// include_directive_scanner
// Finds include directives in a byte stream and emits the quoted file names.
// ----------------------------------------------------------------------------
//  port    | dir | request
//  text_i  | in  | one source byte, stream_last on the final byte of a file
//  res_o   | out | one name byte, or an end marker with name_closed
//
//  A byte is taken every cycle while the queue has room for two results.
//  A byte passes the input register, then the queue, before its first result.
//  The output port gives one result per cycle while res_o.ready is high, so
//  bytes that cause two results (a cut-off name) hand them out in turn.
//  Reset clears the lexer state to line start, normal scanning, empty queue.
//  A stall on res_o backs up the four-entry queue; once three or more
//  results wait while a byte is held, text_i.ready drops.
// ----------------------------------------------------------------------------
module include_directive_scanner import isc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  isc_in_if.sink   text_i,
  isc_out_if.source res_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       room, step;
  isc_push_t  push;
  isc_item_t  item;

  assign step         = in_vld_q && room;
  assign text_i.ready = !in_vld_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (text_i.valid && text_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_i.valid && text_i.ready) begin
      in_byte_q <= text_i.text_byte;
      in_last_q <= text_i.stream_last;
    end
  end

  isc_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .push_o (push)
  );

  isc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (res_o.ready),
    .room_o  (room),
    .valid_o (res_o.valid),
    .item_o  (item)
  );

  assign res_o.name_byte   = item.name_byte;
  assign res_o.angle_form  = item.angle_form;
  assign res_o.name_end    = item.name_end;
  assign res_o.name_closed = item.name_closed;
  assign res_o.run_last    = item.run_last;

endmodule

FILE: rtl/isc_scan.sv
// ----------------------------------------------------------------------------
// isc_scan
// Lexer state for one byte per step; produces up to two name items per byte.
// ----------------------------------------------------------------------------
module isc_scan import isc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output isc_push_t  push_o
);

  typedef enum logic [2:0] {
    ModeNormal  = 3'd0,
    ModeSlash   = 3'd1,
    ModeBlock   = 3'd2,
    ModeLine    = 3'd3,
    ModeKeyword = 3'd4,
    ModeBefore  = 3'd5,
    ModeName    = 3'd6
  } mode_e;

  mode_e      mode_q, mode_d;
  logic       ls_q, ls_d;
  logic       star_q, star_d;
  logic [2:0] match_q, match_d;
  logic       fail_q, fail_d;
  logic       angle_q, angle_d;

  logic       norm, open_chk, emit, is_sp, close_hit;
  isc_item_t  byte_item, end_item;

  always_comb begin
    mode_d    = mode_q;
    ls_d      = ls_q;
    star_d    = star_q;
    match_d   = match_q;
    fail_d    = fail_q;
    angle_d   = angle_q;
    norm      = 1'b0;
    open_chk  = 1'b0;
    emit      = 1'b0;
    is_sp     = (byte_i == ChSpace) || (byte_i == ChTab);
    close_hit = (byte_i == (angle_q ? ChGreater : ChQuote));
    byte_item = '{name_byte: byte_i, angle_form: angle_q, name_end: 1'b0,
                  name_closed: 1'b0, run_last: 1'b0};
    end_item  = '{name_byte: 8'h00, angle_form: angle_q, name_end: 1'b1,
                  name_closed: 1'b1, run_last: 1'b0};

    unique case (mode_q)
      ModeSlash: begin
        if (byte_i == ChStar) begin
          mode_d = ModeBlock;
          star_d = 1'b0;
        end else if (byte_i == ChSlash) begin
          mode_d = ModeLine;
        end else begin
          ls_d = 1'b0;
          norm = 1'b1;
        end
      end
      ModeBlock: begin
        if (star_q && byte_i == ChSlash) begin
          mode_d = ModeNormal;
          star_d = 1'b0;
        end else begin
          star_d = (byte_i == ChStar);
        end
      end
      ModeLine: begin
        if (byte_i == ChNewline) begin
          mode_d = ModeNormal;
          ls_d   = 1'b1;
        end
      end
      ModeKeyword: begin
        priority if (is_sp && match_q == 3'd0 && !fail_q) begin
          // leading blanks after the hash
        end else if (is_ident(byte_i)) begin
          if (!fail_q && match_q < KwLen && byte_i == kw_char(match_q)) begin
            match_d = match_q + 3'd1;
          end else begin
            fail_d = 1'b1;
          end
        end else if (!fail_q && match_q == KwLen) begin
          open_chk = 1'b1;
        end else begin
          ls_d = 1'b0;
          norm = 1'b1;
        end
      end
      ModeBefore: begin
        open_chk = 1'b1;
      end
      ModeName: begin
        if (close_hit) begin
          mode_d = ModeNormal;
          ls_d   = 1'b0;
          byte_item = end_item;
        end
        emit = 1'b1;
      end
      default: begin
        norm = 1'b1;
      end
    endcase

    if (open_chk) begin
      mode_d = ModeBefore;
      priority if (is_sp) begin
        // still waiting for the opener
      end else if (byte_i == ChLess) begin
        mode_d  = ModeName;
        angle_d = 1'b1;
      end else if (byte_i == ChQuote) begin
        mode_d  = ModeName;
        angle_d = 1'b0;
      end else begin
        ls_d = 1'b0;
        norm = 1'b1;
      end
    end

    if (norm) begin
      mode_d = ModeNormal;
      priority if (byte_i == ChNewline) begin
        ls_d = 1'b1;
      end else if (is_sp || byte_i == ChCr) begin
        // blanks keep the line-start mark
      end else if (byte_i == ChHash) begin
        if (ls_d) begin
          mode_d  = ModeKeyword;
          match_d = 3'd0;
          fail_d  = 1'b0;
        end
      end else if (byte_i == ChSlash) begin
        mode_d = ModeSlash;
      end else begin
        ls_d = 1'b0;
      end
    end

    // cut-off name at end of stream
    end_item.angle_form  = angle_d;
    end_item.name_closed = 1'b0;
    end_item.run_last    = 1'b1;
    push_o.item1 = end_item;
    if (last_i && mode_d == ModeName) begin
      if (emit) begin
        push_o.cnt   = 2'd2;
        push_o.item0 = byte_item;
      end else begin
        push_o.cnt   = 2'd1;
        push_o.item0 = end_item;
      end
    end else begin
      push_o.cnt          = emit ? 2'd1 : 2'd0;
      push_o.item0        = byte_item;
      push_o.item0.run_last = 1'b1;
    end
    if (!step_i) begin
      push_o.cnt = 2'd0;
    end

    if (last_i) begin
      mode_d  = ModeNormal;
      ls_d    = 1'b1;
      star_d  = 1'b0;
      match_d = 3'd0;
      fail_d  = 1'b0;
      angle_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeNormal;
      ls_q    <= 1'b1;
      star_q  <= 1'b0;
      match_q <= 3'd0;
      fail_q  <= 1'b0;
      angle_q <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      ls_q    <= ls_d;
      star_q  <= star_d;
      match_q <= match_d;
      fail_q  <= fail_d;
      angle_q <= angle_d;
    end
  end

endmodule

FILE: rtl/isc_queue.sv
// ----------------------------------------------------------------------------
// isc_queue
// Small result queue: takes up to two items per cycle, gives one per cycle while popped.
// ----------------------------------------------------------------------------
module isc_queue import isc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  isc_push_t push_i,
  input  logic      pop_i,
  output logic      room_o,
  output logic      valid_o,
  output isc_item_t item_o
);

  isc_item_t              mem_q [QDepth];
  logic [QPtrW-1:0]       wr_q, rd_q;
  logic [QCntW-1:0]       cnt_q;
  logic [QPtrW-1:0]       wr_next;

  assign wr_next = wr_q + QPtrW'(1);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  // room for a full pair of results
  assign room_o  = (cnt_q <= QCntW'(QDepth - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.item0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_next] <= push_i.item1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPtrW'(push_i.cnt);
      if (pop_i && valid_o) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + QCntW'(push_i.cnt) - QCntW'(pop_i && valid_o);
    end
  end

endmodule

FILE: rtl/isc_checker.sv
// ----------------------------------------------------------------------------
// isc_checker
// Port-level checks on the result channel of the include scanner.
// ----------------------------------------------------------------------------
module isc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] name_byte_i,
  input logic       name_end_i,
  input logic       name_closed_i,
  input logic       run_last_i
);

  // a stalled result holds its byte, end flag and run_last
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(name_byte_i) &&
    $stable(name_end_i) && $stable(run_last_i))
    else $error("result changed while stalled");

  // both results of one byte are queued together, so the second follows
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !run_last_i |=> out_valid_i)
    else $error("second result of a byte not ready");

  a_end_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && name_end_i |-> name_byte_i == 8'h00)
    else $error("end marker carries a byte");

  // a cut-off name only happens on the final byte, its end item comes last
  a_cutoff_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && name_end_i && !name_closed_i |-> run_last_i)
    else $error("unclosed end marker not last of its byte");

endmodule

bind include_directive_scanner isc_checker u_isc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .name_byte_i   (res_o.name_byte),
  .name_end_i    (res_o.name_end),
  .name_closed_i (res_o.name_closed),
  .run_last_i    (res_o.run_last)
);

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for include_directive_scanner. Source bytes are sent on text_i,
// a lexer model in the bench predicts the name bytes and end markers, and
// every result on res_o is compared field by field with the oldest
// prediction. Directed cases come first, then random source snippets under
// three flow-control profiles.
// ----------------------------------------------------------------------------
module tb_top import isc_pkg::*; ();

  typedef enum logic [2:0] {
    ScanNormal, ScanSlash, ScanBlock, ScanLine, ScanKeyword, ScanBefore, ScanName
  } scan_mode_e;

  localparam string       Keyword     = "include";
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned WaitLimit   = 100000;

  logic clk;
  logic rst_n;

  isc_in_if  text_if ();
  isc_out_if res_if ();

  include_directive_scanner dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .text_i (text_if),
    .res_o  (res_if)
  );

  // lexer model state
  scan_mode_e  lex_mode;
  bit          at_line_start;
  bit          star_pending;
  int unsigned kw_count;
  bit          kw_bad;
  bit          angle_name;

  isc_item_t   pending_names[$];
  logic [7:0]  snippet_bytes[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned name_bytes_seen;
  int unsigned names_closed;
  int unsigned names_cut;

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic void lexer_reset();
    lex_mode      = ScanNormal;
    at_line_start = 1'b1;
    star_pending  = 1'b0;
    kw_count      = 0;
    kw_bad        = 1'b0;
    angle_name    = 1'b0;
  endfunction

  function automatic bit ident_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
           (c >= "A" && c <= "Z") || c == ChUnder;
  endfunction

  function automatic void scan_plain(input logic [7:0] c);
    lex_mode = ScanNormal;
    if (c == ChNewline) begin
      at_line_start = 1'b1;
    end else if (c == ChSpace || c == ChTab || c == ChCr) begin
      // whitespace leaves the mark alone
    end else if (c == ChHash) begin
      if (at_line_start) begin
        lex_mode = ScanKeyword;
        kw_count = 0;
        kw_bad   = 1'b0;
      end
    end else if (c == ChSlash) begin
      lex_mode = ScanSlash;
    end else begin
      at_line_start = 1'b0;
    end
  endfunction

  function automatic void end_directive(input logic [7:0] c);
    at_line_start = 1'b0;
    scan_plain(c);
  endfunction

  function automatic void scan_opener(input logic [7:0] c);
    lex_mode = ScanBefore;
    if (c == ChLess) begin
      lex_mode   = ScanName;
      angle_name = 1'b1;
    end else if (c == ChQuote) begin
      lex_mode   = ScanName;
      angle_name = 1'b0;
    end else if (c != ChSpace && c != ChTab) begin
      end_directive(c);
    end
  endfunction

  function automatic isc_item_t name_item(input logic [7:0] b, input logic is_end,
                                          input logic closed);
    isc_item_t it;
    it.name_byte   = b;
    it.angle_form  = angle_name;
    it.name_end    = is_end;
    it.name_closed = closed;
    it.run_last    = 1'b0;
    return it;
  endfunction

  function automatic void predict_byte(input logic [7:0] c, input logic last);
    isc_item_t step_items[$];
    case (lex_mode)
      ScanSlash: begin
        if (c == ChStar) begin
          lex_mode     = ScanBlock;
          star_pending = 1'b0;
        end else if (c == ChSlash) begin
          lex_mode = ScanLine;
        end else begin
          at_line_start = 1'b0;
          scan_plain(c);
        end
      end
      ScanBlock: begin
        if (star_pending && c == ChSlash) begin
          lex_mode     = ScanNormal;
          star_pending = 1'b0;
        end else begin
          star_pending = (c == ChStar);
        end
      end
      ScanLine: begin
        if (c == ChNewline) begin
          lex_mode      = ScanNormal;
          at_line_start = 1'b1;
        end
      end
      ScanKeyword: begin
        if ((c == ChSpace || c == ChTab) && kw_count == 0 && !kw_bad) begin
          // blanks between hash and keyword
        end else if (ident_char(c)) begin
          if (!kw_bad && kw_count < KwLen && c == Keyword[kw_count]) kw_count++;
          else kw_bad = 1'b1;
        end else if (!kw_bad && kw_count == KwLen) begin
          scan_opener(c);
        end else begin
          end_directive(c);
        end
      end
      ScanBefore: scan_opener(c);
      ScanName: begin
        if (c == (angle_name ? ChGreater : ChQuote)) begin
          step_items.insert(step_items.size(), name_item(8'h00, 1'b1, 1'b1));
          lex_mode      = ScanNormal;
          at_line_start = 1'b0;
        end else begin
          step_items.insert(step_items.size(), name_item(c, 1'b0, 1'b0));
        end
      end
      default: scan_plain(c);
    endcase

    if (last) begin
      if (lex_mode == ScanName) begin
        step_items.insert(step_items.size(), name_item(8'h00, 1'b1, 1'b0));
      end
      lexer_reset();
    end

    if (step_items.size() > 0) step_items[step_items.size() - 1].run_last = 1'b1;
    foreach (step_items[i]) pending_names.insert(pending_names.size(), step_items[i]);
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result();
    isc_item_t want;
    if (pending_names.size() == 0) begin
      $error("unexpected result: name_byte %0h name_end %0b", res_if.name_byte,
             res_if.name_end);
      mismatches++;
      return;
    end
    want = pending_names.pop_front();
    check_field("name_byte", want.name_byte, res_if.name_byte);
    check_field("angle_form", want.angle_form, res_if.angle_form);
    check_field("name_end", want.name_end, res_if.name_end);
    check_field("name_closed", want.name_closed, res_if.name_closed);
    check_field("run_last", want.run_last, res_if.run_last);
    if (!want.name_end) name_bytes_seen++;
    else if (want.name_closed) names_closed++;
    else names_cut++;
  endfunction

  initial begin : result_monitor
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1) check_result();
      res_if.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      text_if.valid <= 1'b0;
      @(posedge clk);
    end
    text_if.valid       <= 1'b1;
    text_if.text_byte   <= b;
    text_if.stream_last <= last;
    @(posedge clk);
    while (text_if.ready !== 1'b1) @(posedge clk);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], last && i == s.len() - 1);
  endtask

  function automatic void append_byte(input logic [7:0] b);
    snippet_bytes.insert(snippet_bytes.size(), b);
  endfunction

  function automatic logic [7:0] pick_blank(input bit with_cr);
    case ($urandom_range(with_cr ? 2 : 1))
      0: return ChSpace;
      1: return ChTab;
      default: return ChCr;
    endcase
  endfunction

  function automatic void add_block_comment();
    int unsigned n;
    n = $urandom_range(5);
    append_byte(ChSlash);
    append_byte(ChStar);
    repeat (n) begin
      case ($urandom_range(3))
        0: append_byte(ChStar);
        1: append_byte(ChSlash);
        2: append_byte(ChNewline);
        default: append_byte(8'($urandom_range(255)));
      endcase
    end
    append_byte(ChStar);
    append_byte(ChSlash);
  endfunction

  function automatic void add_directive();
    int unsigned n;
    int unsigned bad_pos;
    int unsigned flavor;
    logic [7:0]  closer;
    logic [7:0]  b;
    bit          angle;
    repeat ($urandom_range(2)) append_byte(pick_blank(1'b1));
    if ($urandom_range(3) == 0) add_block_comment();
    append_byte(ChHash);
    repeat ($urandom_range(2)) append_byte(pick_blank(1'b0));

    // mostly the exact keyword, sometimes a misspelled, longer or shorter one
    flavor  = $urandom_range(9);
    bad_pos = $urandom_range(KwLen - 1);
    n       = (flavor == 2) ? bad_pos : KwLen;
    for (int i = 0; i < n; i++) begin
      if (flavor == 0 && i == bad_pos) append_byte(8'("a" + $urandom_range(25)));
      else append_byte(Keyword[i]);
    end
    if (flavor == 1) append_byte(ChUnder);

    repeat ($urandom_range(2)) append_byte(pick_blank(1'b0));
    angle  = $urandom_range(1);
    closer = angle ? ChGreater : ChQuote;
    if ($urandom_range(9) == 0) begin
      append_byte(8'($urandom_range(255)));
    end else begin
      append_byte(angle ? ChLess : ChQuote);
      repeat ($urandom_range(6)) begin
        b = ($urandom_range(7) == 0) ? ChNewline : 8'($urandom_range(255));
        if (b == closer) b = b ^ 8'h01;
        append_byte(b);
      end
      if ($urandom_range(9) != 0) append_byte(closer);
    end

    // trailing junk, a hash here must not open a second directive
    if ($urandom_range(2) == 0) append_byte(ChHash);
    if ($urandom_range(3) == 0) append_byte(8'($urandom_range(255)));
    if ($urandom_range(4) != 0) append_byte(ChNewline);
  endfunction

  task automatic send_snippet();
    int unsigned stop_at;
    bit          ends_stream;
    snippet_bytes.delete();
    case ($urandom_range(9))
      6: add_block_comment();
      7: begin
        append_byte(ChSlash);
        append_byte(ChSlash);
        repeat ($urandom_range(4)) append_byte(8'($urandom_range(255)));
        append_byte(ChNewline);
      end
      8: begin
        append_byte(ChSlash);
        append_byte(8'($urandom_range(255)));
      end
      9: repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(255)));
      default: add_directive();
    endcase
    ends_stream = ($urandom_range(5) == 0);
    stop_at     = ends_stream ? $urandom_range(snippet_bytes.size() - 1)
                              : snippet_bytes.size() - 1;
    for (int i = 0; i <= stop_at; i++) begin
      send_byte(snippet_bytes[i], ends_stream && i == stop_at);
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < count) send_snippet();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // comment ahead of the hash, extreme and newline bytes inside the name
    send_text("/**/#include<", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(ChNewline, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(ChGreater, 1'b0);
    // hash right after a directive is plain text, stream ends here
    send_byte(ChHash, 1'b1);
    // quoted name cut off by the end of the stream
    send_text("#include\"z", 1'b1);
  endtask

  task automatic test_slow_receiver();
    send_idle_pct  = 33;
    recv_stall_pct = 82;
    run_random(330);
  endtask

  task automatic test_slow_sender();
    send_idle_pct  = 82;
    recv_stall_pct = 33;
    run_random(330);
  endtask

  task automatic test_full_rate();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(340);
  endtask

  initial begin : stimulus
    int unsigned waited;
    text_if.valid       = 1'b0;
    text_if.text_byte   = 8'h00;
    text_if.stream_last = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    mismatches          = 0;
    bytes_sent          = 0;
    name_bytes_seen     = 0;
    names_closed        = 0;
    names_cut           = 0;
    lexer_reset();
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_slow_receiver();
    test_slow_sender();
    test_full_rate();

    text_if.valid <= 1'b0;
    waited = 0;
    while (pending_names.size() != 0 && waited < WaitLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk);
    if (pending_names.size() != 0) begin
      $error("%0d predicted results never arrived", pending_names.size());
      mismatches++;
    end

    $display("scanned %0d source bytes under three flow-control profiles",
             bytes_sent);
    $display("names: %0d bytes, %0d closed, %0d cut off by stream end",
             name_bytes_seen, names_closed, names_cut);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: files.f
rtl/isc_pkg.sv
rtl/isc_if.sv
rtl/isc_scan.sv
rtl/isc_queue.sv
rtl/include_directive_scanner.sv
rtl/isc_checker.sv
dv/tb_top.sv
